// File: sv/etm_pkg.sv
// ----------------------------------------------------------------------------
// etm_pkg
// shared types and constants of the euler model-matrix block
// ----------------------------------------------------------------------------
package etm_pkg;

   // fixed port widths
   localparam int ANGLE_W = 16;
   localparam int SCALE_W = 24;
   localparam int TRANS_W = 32;
   localparam int ENTRY_W = 24;

   // side data carried next to the sine units: quadrants, scales, translations
   localparam int SIDE_W = 6 + 3 * SCALE_W + 3 * TRANS_W;

   // sine series working format, unsigned Q2.30
   localparam int WORK_BITS = 30;
   localparam logic [30:0] HALF_PI_WORK = 31'd1686629713;
   localparam int SERIES_TERMS = 8;

   // sine unit latency: angle scale, square, three per series term, final product
   localparam int SIN_LAT = 3 * SERIES_TERMS + 3;

   // stages behind the sine units: trig, pairs, triples, sums, scale product, output
   localparam int BACK_LAT = SIN_LAT + 6;

   localparam int QUEUE_DEPTH = 4;

   localparam int ENTRY_MAX = 8388607;
   localparam int ENTRY_MIN = -8388608;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // width of one classified item between front and back
   function automatic int item_width(input int angle_bits);
      return 6 * (angle_bits - 1) + SIDE_W;
   endfunction

endpackage

// File: sv/euler_trs_model_matrix.sv
// ----------------------------------------------------------------------------
// euler_trs_model_matrix
// y-x-z euler rotate-scale matrix with translation pass-through
// ----------------------------------------------------------------------------
// Takes one item per clock while rsp_ready is high and returns one result per
// item, in order: the nine rotate-scale entries in column-major order (signed
// Q8.16, saturated) and the translation unchanged. An accepted item passes the
// input register, the four-entry queue, the sine units (eight-term series at
// three stages per term) and six product/scale/output stages. Angles use their
// low ANGLE_BITS bits, 2^ANGLE_BITS being a full turn.
module euler_trs_model_matrix #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [etm_pkg::ANGLE_W-1:0]        req_angle_x,
   input  logic [etm_pkg::ANGLE_W-1:0]        req_angle_y,
   input  logic [etm_pkg::ANGLE_W-1:0]        req_angle_z,
   input  logic signed [etm_pkg::SCALE_W-1:0] req_scale_x,
   input  logic signed [etm_pkg::SCALE_W-1:0] req_scale_y,
   input  logic signed [etm_pkg::SCALE_W-1:0] req_scale_z,
   input  logic signed [etm_pkg::TRANS_W-1:0] req_trans_x,
   input  logic signed [etm_pkg::TRANS_W-1:0] req_trans_y,
   input  logic signed [etm_pkg::TRANS_W-1:0] req_trans_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [etm_pkg::ENTRY_W-1:0] rsp_col0_row0,
   output logic signed [etm_pkg::ENTRY_W-1:0] rsp_col0_row1,
   output logic signed [etm_pkg::ENTRY_W-1:0] rsp_col0_row2,
   output logic signed [etm_pkg::ENTRY_W-1:0] rsp_col1_row0,
   output logic signed [etm_pkg::ENTRY_W-1:0] rsp_col1_row1,
   output logic signed [etm_pkg::ENTRY_W-1:0] rsp_col1_row2,
   output logic signed [etm_pkg::ENTRY_W-1:0] rsp_col2_row0,
   output logic signed [etm_pkg::ENTRY_W-1:0] rsp_col2_row1,
   output logic signed [etm_pkg::ENTRY_W-1:0] rsp_col2_row2,
   output logic signed [etm_pkg::TRANS_W-1:0] rsp_out_tx,
   output logic signed [etm_pkg::TRANS_W-1:0] rsp_out_ty,
   output logic signed [etm_pkg::TRANS_W-1:0] rsp_out_tz
);

   localparam int ITEM_W = etm_pkg::item_width(ANGLE_BITS);

   logic                   f_valid;
   logic [ITEM_W-1:0]      f_item;
   logic [ITEM_W-1:0]      q_item;
   logic                   q_pop;
   etm_pkg::fifo_stat_type q_stat;

   // front: accept and classify
   etm_front #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_angle_x(req_angle_x),
      .req_angle_y(req_angle_y),
      .req_angle_z(req_angle_z),
      .req_scale_x(req_scale_x),
      .req_scale_y(req_scale_y),
      .req_scale_z(req_scale_z),
      .req_trans_x(req_trans_x),
      .req_trans_y(req_trans_y),
      .req_trans_z(req_trans_z),
      .q_stat     (q_stat),
      .item_valid (f_valid),
      .item       (f_item)
   );

   // decoupling queue
   etm_queue #(
      .WIDTH(ITEM_W),
      .DEPTH(etm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_data (f_item),
      .pop       (q_pop),
      .pop_data  (q_item),
      .stat      (q_stat)
   );

   // back: trig, products, output
   etm_back #(
      .ANGLE_BITS(ANGLE_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (!q_stat.empty),
      .in_item      (q_item),
      .in_pop       (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_col0_row0(rsp_col0_row0),
      .rsp_col0_row1(rsp_col0_row1),
      .rsp_col0_row2(rsp_col0_row2),
      .rsp_col1_row0(rsp_col1_row0),
      .rsp_col1_row1(rsp_col1_row1),
      .rsp_col1_row2(rsp_col1_row2),
      .rsp_col2_row0(rsp_col2_row0),
      .rsp_col2_row1(rsp_col2_row1),
      .rsp_col2_row2(rsp_col2_row2),
      .rsp_out_tx   (rsp_out_tx),
      .rsp_out_ty   (rsp_out_ty),
      .rsp_out_tz   (rsp_out_tz)
   );

endmodule

// File: sv/etm_front.sv
// ----------------------------------------------------------------------------
// etm_front
// input register; splits each angle into quadrant and sine/cosine arguments
// ----------------------------------------------------------------------------
module etm_front #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic [etm_pkg::ANGLE_W-1:0]                   req_angle_x,
   input  logic [etm_pkg::ANGLE_W-1:0]                   req_angle_y,
   input  logic [etm_pkg::ANGLE_W-1:0]                   req_angle_z,
   input  logic signed [etm_pkg::SCALE_W-1:0]            req_scale_x,
   input  logic signed [etm_pkg::SCALE_W-1:0]            req_scale_y,
   input  logic signed [etm_pkg::SCALE_W-1:0]            req_scale_z,
   input  logic signed [etm_pkg::TRANS_W-1:0]            req_trans_x,
   input  logic signed [etm_pkg::TRANS_W-1:0]            req_trans_y,
   input  logic signed [etm_pkg::TRANS_W-1:0]            req_trans_z,
   input  etm_pkg::fifo_stat_type                        q_stat,
   output logic                                          item_valid,
   output logic [etm_pkg::item_width(ANGLE_BITS)-1:0]    item
);

   localparam int ITEM_W = etm_pkg::item_width(ANGLE_BITS);
   localparam int GW = ANGLE_BITS - 1;
   localparam logic [GW-1:0] QUARTER = GW'(1) << (ANGLE_BITS - 2);

   logic              vld_ff, vld_in;
   logic [ITEM_W-1:0] item_ff, item_in;
   logic              take;

   // quadrant and the two first-quadrant arguments of one angle
   function automatic logic [2*GW+1:0] classify(input logic [etm_pkg::ANGLE_W-1:0] ang);
      logic [ANGLE_BITS-1:0] a;
      logic [GW-1:0]         gs;
      a  = ANGLE_BITS'(ang);
      gs = GW'(a[ANGLE_BITS-3:0]);
      return {a[ANGLE_BITS-1 -: 2], QUARTER - gs, gs};
   endfunction

   logic [2*GW+1:0] cx, cy, cz;

   assign cx = classify(req_angle_x);
   assign cy = classify(req_angle_y);
   assign cz = classify(req_angle_z);

   // classified item layout, low to high: args, quadrants, scales, translations
   assign item_in = {req_trans_z, req_trans_y, req_trans_x,
                     req_scale_z, req_scale_y, req_scale_x,
                     cz[2*GW +: 2], cy[2*GW +: 2], cx[2*GW +: 2],
                     cz[2*GW-1:0], cy[2*GW-1:0], cx[2*GW-1:0]};

   assign req_ready = !vld_ff || !q_stat.full;
   assign take      = req_valid && req_ready;

   // held item leaves when the queue has room
   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (!q_stat.full) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

// File: sv/etm_queue.sv
// ----------------------------------------------------------------------------
// etm_queue
// short fifo between the front and the back pipeline
// ----------------------------------------------------------------------------
module etm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_data,
   output etm_pkg::fifo_stat_type stat
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             push;

   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign push       = push_valid && !stat.full;
   assign pop_data   = slot_ff[rd_ff];

   // pointers wrap at the power-of-two depth
   always_comb begin
      wr_in  = push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: sv/etm_sin.sv
// ----------------------------------------------------------------------------
// etm_sin
// pipelined first-quadrant sine: horner taylor series in q2.30
// ----------------------------------------------------------------------------
module etm_sin #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-2:0] g,
   output logic [FRAC_BITS:0]    m
);

   localparam int GW = ANGLE_BITS - 1;
   localparam int WB = etm_pkg::WORK_BITS;
   localparam int N  = etm_pkg::SERIES_TERMS;
   localparam int SH = WB - FRAC_BITS;
   localparam logic [30:0] ONE = 31'(1) << WB;
   localparam logic [31:0] RND = 32'(1) << (SH - 1);

   // stage: scale angle to radians
   logic [GW+30:0] xa_prod;
   logic [30:0]    xa_ff, xa_in;

   assign xa_prod = (GW + 31)'(g) * (GW + 31)'(etm_pkg::HALF_PI_WORK);
   assign xa_in   = xa_prod[ANGLE_BITS-2 +: 31];

   always_ff @(posedge clock) begin
      if (en) begin
         xa_ff <= xa_in;
      end
   end

   // stage: square
   logic [30:0] x_ff  [N+1];
   logic [31:0] x2_ff [N+1];
   logic [30:0] h_ff  [N+1];
   logic [61:0] sq_prod;

   assign sq_prod = 62'(xa_ff) * 62'(xa_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= xa_ff;
         x2_ff[0] <= sq_prod[WB +: 32];
         h_ff[0]  <= ONE;
      end
   end

   // one series term per three stages: product, reciprocal divide, correct
   for (genvar i = 0; i < N; i++) begin : g_term
      localparam int K = N - i;
      localparam logic [8:0] D = 9'((2 * K) * (2 * K + 1));
      localparam logic [63:0] RCP = (64'd1 << 32) / 64'(D);

      logic [62:0] t_prod;
      logic [31:0] t1_ff, t2_ff;
      logic [30:0] xa1_ff, xa2_ff;
      logic [31:0] x2a1_ff, x2a2_ff;
      logic [61:0] q_prod;
      logic [29:0] q0_ff;
      logic [38:0] d_prod;
      logic [31:0] rem;
      logic [30:0] q_fix;

      assign t_prod = 63'(x2_ff[i]) * 63'(h_ff[i]);

      always_ff @(posedge clock) begin
         if (en) begin
            t1_ff   <= t_prod[WB +: 32];
            xa1_ff  <= x_ff[i];
            x2a1_ff <= x2_ff[i];
         end
      end

      assign q_prod = 62'(t1_ff) * 62'(RCP[29:0]);

      always_ff @(posedge clock) begin
         if (en) begin
            q0_ff   <= q_prod[32 +: 30];
            t2_ff   <= t1_ff;
            xa2_ff  <= xa1_ff;
            x2a2_ff <= x2a1_ff;
         end
      end

      // estimate is low by at most one
      assign d_prod = 39'(q0_ff) * 39'(D);
      assign rem    = t2_ff - d_prod[31:0];
      assign q_fix  = 31'(q0_ff) + 31'(rem >= 32'(D));

      always_ff @(posedge clock) begin
         if (en) begin
            h_ff[i+1]  <= ONE - q_fix;
            x_ff[i+1]  <= xa2_ff;
            x2_ff[i+1] <= x2a2_ff;
         end
      end
   end

   // stage: final product, cap at one, round to output fraction
   logic [61:0]      f_prod;
   logic [31:0]      s_raw, s_cap, s_rnd;
   logic [FRAC_BITS:0] m_ff;

   assign f_prod = 62'(x_ff[N]) * 62'(h_ff[N]);
   assign s_raw  = f_prod[WB +: 32];
   assign s_cap  = (s_raw > 32'(ONE)) ? 32'(ONE) : s_raw;
   assign s_rnd  = s_cap + RND;

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff <= s_rnd[SH +: FRAC_BITS + 1];
      end
   end

   assign m = m_ff;

endmodule

// File: sv/etm_back.sv
// ----------------------------------------------------------------------------
// etm_back
// sine/cosine units, matrix products, scaling with saturation, output stage
// ----------------------------------------------------------------------------
module etm_back #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  logic [etm_pkg::item_width(ANGLE_BITS)-1:0] in_item,
   output logic                                       in_pop,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [etm_pkg::ENTRY_W-1:0]         rsp_col0_row0,
   output logic signed [etm_pkg::ENTRY_W-1:0]         rsp_col0_row1,
   output logic signed [etm_pkg::ENTRY_W-1:0]         rsp_col0_row2,
   output logic signed [etm_pkg::ENTRY_W-1:0]         rsp_col1_row0,
   output logic signed [etm_pkg::ENTRY_W-1:0]         rsp_col1_row1,
   output logic signed [etm_pkg::ENTRY_W-1:0]         rsp_col1_row2,
   output logic signed [etm_pkg::ENTRY_W-1:0]         rsp_col2_row0,
   output logic signed [etm_pkg::ENTRY_W-1:0]         rsp_col2_row1,
   output logic signed [etm_pkg::ENTRY_W-1:0]         rsp_col2_row2,
   output logic signed [etm_pkg::TRANS_W-1:0]         rsp_out_tx,
   output logic signed [etm_pkg::TRANS_W-1:0]         rsp_out_ty,
   output logic signed [etm_pkg::TRANS_W-1:0]         rsp_out_tz
);

   localparam int GW   = ANGLE_BITS - 1;
   localparam int SW   = etm_pkg::SIDE_W;
   localparam int SL   = etm_pkg::SIN_LAT;
   localparam int TOT  = etm_pkg::BACK_LAT;
   localparam int TW   = FRAC_BITS + 2;
   localparam int RW   = TW + 1;
   localparam int KW   = etm_pkg::SCALE_W;
   localparam int EW   = etm_pkg::ENTRY_W;
   localparam int PW   = KW + RW;
   localparam int VW   = PW - FRAC_BITS;
   localparam int KOFF = 6;
   localparam int TOFF = 6 + 3 * KW;
   localparam logic signed [2*TW-1:0] HALF_T = (2 * TW)'(1) << (FRAC_BITS - 1);
   localparam logic signed [PW-1:0]   HALF_P = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [VW-1:0]   VMAX   = VW'(etm_pkg::ENTRY_MAX);
   localparam logic signed [VW-1:0]   VMIN   = VW'(etm_pkg::ENTRY_MIN);

   logic adv;

   assign adv    = !rsp_valid || rsp_ready;
   assign in_pop = adv && in_valid;

   // valid and side data run beside the arithmetic
   logic          vld_ff  [TOT];
   logic [SW-1:0] side_ff [TOT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < TOT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_item[6*GW +: SW];
         for (int i = 1; i < TOT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // six sine units: sin and cos argument per axis
   logic [FRAC_BITS:0] m_w [6];

   for (genvar i = 0; i < 6; i++) begin : g_sin
      etm_sin #(
         .ANGLE_BITS(ANGLE_BITS),
         .FRAC_BITS (FRAC_BITS)
      ) u_sin (
         .clock(clock),
         .en   (adv),
         .g    (in_item[i*GW +: GW]),
         .m    (m_w[i])
      );
   end

   // fold quadrant into signed sin and cos
   function automatic logic [2*TW-1:0] unfold(input logic [1:0] quad,
                                              input logic [FRAC_BITS:0] ms,
                                              input logic [FRAC_BITS:0] mc);
      logic signed [TW-1:0] s;
      logic signed [TW-1:0] c;
      logic signed [TW-1:0] sn;
      logic signed [TW-1:0] cs;
      s = signed'(TW'(ms));
      c = signed'(TW'(mc));
      unique case (etm_pkg::quad_type'(quad))
         etm_pkg::QUAD_0: begin sn = s;  cs = c;  end
         etm_pkg::QUAD_1: begin sn = c;  cs = -s; end
         etm_pkg::QUAD_2: begin sn = -s; cs = -c; end
         etm_pkg::QUAD_3: begin sn = -c; cs = s;  end
         default:         begin sn = s;  cs = c;  end
      endcase
      return {sn, cs};
   endfunction

   // fixed-point product, rounded half up
   function automatic logic signed [TW-1:0] mulq(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
      logic signed [2*TW-1:0] p;
      p = a * b;
      p = p + HALF_T;
      return p[FRAC_BITS +: TW];
   endfunction

   // trig stage
   logic [2*TW-1:0] ux, uy, uz;
   logic signed [TW-1:0] sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff;

   assign ux = unfold(side_ff[SL-1][0 +: 2], m_w[0], m_w[1]);
   assign uy = unfold(side_ff[SL-1][2 +: 2], m_w[2], m_w[3]);
   assign uz = unfold(side_ff[SL-1][4 +: 2], m_w[4], m_w[5]);

   always_ff @(posedge clock) begin
      if (adv) begin
         {sx_ff, cx_ff} <= ux;
         {sy_ff, cy_ff} <= uy;
         {sz_ff, cz_ff} <= uz;
      end
   end

   // pair products
   logic signed [TW-1:0] cycz1_ff, cxsz1_ff, czsy1_ff, cysz1_ff, cxcz1_ff;
   logic signed [TW-1:0] sysz1_ff, cxsy1_ff, cycx1_ff, sysx1_ff, cysx1_ff;
   logic signed [TW-1:0] sx1_ff, sz1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cycz1_ff <= mulq(cy_ff, cz_ff);
         cxsz1_ff <= mulq(cx_ff, sz_ff);
         czsy1_ff <= mulq(cz_ff, sy_ff);
         cysz1_ff <= mulq(cy_ff, sz_ff);
         cxcz1_ff <= mulq(cx_ff, cz_ff);
         sysz1_ff <= mulq(sy_ff, sz_ff);
         cxsy1_ff <= mulq(cx_ff, sy_ff);
         cycx1_ff <= mulq(cy_ff, cx_ff);
         sysx1_ff <= mulq(sy_ff, sx_ff);
         cysx1_ff <= mulq(cy_ff, sx_ff);
         sx1_ff   <= sx_ff;
         sz1_ff   <= sz_ff;
      end
   end

   // triple products, left to right
   logic signed [TW-1:0] ta_ff, tb_ff, tc_ff, td_ff;
   logic signed [TW-1:0] cycz2_ff, cxsz2_ff, czsy2_ff, cysz2_ff, cxcz2_ff;
   logic signed [TW-1:0] sysz2_ff, cxsy2_ff, cycx2_ff, sx2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ta_ff    <= mulq(sysx1_ff, sz1_ff);
         tb_ff    <= mulq(cysx1_ff, sz1_ff);
         tc_ff    <= mulq(czsy1_ff, sx1_ff);
         td_ff    <= mulq(cycz1_ff, sx1_ff);
         cycz2_ff <= cycz1_ff;
         cxsz2_ff <= cxsz1_ff;
         czsy2_ff <= czsy1_ff;
         cysz2_ff <= cysz1_ff;
         cxcz2_ff <= cxcz1_ff;
         sysz2_ff <= sysz1_ff;
         cxsy2_ff <= cxsy1_ff;
         cycx2_ff <= cycx1_ff;
         sx2_ff   <= sx1_ff;
      end
   end

   // rotation entries, column-major
   logic signed [RW-1:0] r_ff [9];
   logic signed [RW-1:0] r_in [9];

   always_comb begin
      r_in[0] = RW'(cycz2_ff) + RW'(ta_ff);
      r_in[1] = RW'(cxsz2_ff);
      r_in[2] = RW'(tb_ff) - RW'(czsy2_ff);
      r_in[3] = RW'(tc_ff) - RW'(cysz2_ff);
      r_in[4] = RW'(cxcz2_ff);
      r_in[5] = RW'(td_ff) + RW'(sysz2_ff);
      r_in[6] = RW'(cxsy2_ff);
      r_in[7] = -RW'(sx2_ff);
      r_in[8] = RW'(cycx2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff <= r_in;
      end
   end

   // scale products, then round and saturate into the output register
   logic signed [PW-1:0] e_ff  [9];
   logic signed [EW-1:0] out_ff [9];

   for (genvar i = 0; i < 9; i++) begin : g_entry
      localparam int COL = i / 3;

      logic signed [KW-1:0] k;
      logic signed [PW-1:0] e_rnd;
      logic signed [VW-1:0] v;
      logic signed [EW-1:0] sat;

      assign k     = signed'(side_ff[SL+3][KOFF + COL*KW +: KW]);
      assign e_rnd = e_ff[i] + HALF_P;
      assign v     = e_rnd[FRAC_BITS +: VW];

      always_comb begin
         priority if (v > VMAX) begin
            sat = EW'(etm_pkg::ENTRY_MAX);
         end else if (v < VMIN) begin
            sat = EW'(etm_pkg::ENTRY_MIN);
         end else begin
            sat = v[EW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            e_ff[i]   <= PW'(k) * PW'(r_ff[i]);
            out_ff[i] <= sat;
         end
      end
   end

   assign rsp_valid     = vld_ff[TOT-1];
   assign rsp_col0_row0 = out_ff[0];
   assign rsp_col0_row1 = out_ff[1];
   assign rsp_col0_row2 = out_ff[2];
   assign rsp_col1_row0 = out_ff[3];
   assign rsp_col1_row1 = out_ff[4];
   assign rsp_col1_row2 = out_ff[5];
   assign rsp_col2_row0 = out_ff[6];
   assign rsp_col2_row1 = out_ff[7];
   assign rsp_col2_row2 = out_ff[8];
   assign rsp_out_tx    = signed'(side_ff[TOT-1][TOFF +: etm_pkg::TRANS_W]);
   assign rsp_out_ty    = signed'(side_ff[TOT-1][TOFF + etm_pkg::TRANS_W +: etm_pkg::TRANS_W]);
   assign rsp_out_tz    = signed'(side_ff[TOT-1][TOFF + 2*etm_pkg::TRANS_W +: etm_pkg::TRANS_W]);

endmodule

// File: tb/sv/tb_euler_trs_model_matrix.sv
// ----------------------------------------------------------------------------
// tb_euler_trs_model_matrix
// checks the euler rotate-scale matrix block against a fixed-point predictor
// ----------------------------------------------------------------------------
// A directed table covers zero and quarter-turn angles, quadrant edges, scale
// and translation extremes and saturation. Random transforms follow with
// bursty idling on both sides, a long receiver hold-off and a drain pause.
// Every result is compared in full with the oldest expected matrix.
module tb_euler_trs_model_matrix;

   localparam int FRAC = 16;
   localparam int ABITS = 16;
   localparam int N_RANDOM = 630;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [etm_pkg::ANGLE_W-1:0] ax, ay, az;
      logic signed [etm_pkg::SCALE_W-1:0] kx, ky, kz;
      logic signed [etm_pkg::TRANS_W-1:0] tx, ty, tz;
   } transform_type;

   typedef struct packed {
      logic signed [etm_pkg::ENTRY_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
      logic signed [etm_pkg::TRANS_W-1:0] tx, ty, tz;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   transform_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   matrix_type rsp_item;

   matrix_type expected_matrices[$];
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit rx_hold = 1'b0;
   bit quiet_phase = 1'b0;
   bit timed_out = 1'b0;
   bit row_known = 1'b0;
   matrix_type row_result = '0;

   euler_trs_model_matrix DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_angle_x(req_item.ax), .req_angle_y(req_item.ay), .req_angle_z(req_item.az),
      .req_scale_x(req_item.kx), .req_scale_y(req_item.ky), .req_scale_z(req_item.kz),
      .req_trans_x(req_item.tx), .req_trans_y(req_item.ty), .req_trans_z(req_item.tz),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_col0_row0(rsp_item.m00), .rsp_col0_row1(rsp_item.m01),
      .rsp_col0_row2(rsp_item.m02), .rsp_col1_row0(rsp_item.m10),
      .rsp_col1_row1(rsp_item.m11), .rsp_col1_row2(rsp_item.m12),
      .rsp_col2_row0(rsp_item.m20), .rsp_col2_row1(rsp_item.m21),
      .rsp_col2_row2(rsp_item.m22),
      .rsp_out_tx(rsp_item.tx), .rsp_out_ty(rsp_item.ty), .rsp_out_tz(rsp_item.tz)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- predictor ----------------

   // round to FRAC fraction bits, ties toward plus infinity
   function automatic longint fx_round(input longint v);
      return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      return fx_round(a * b);
   endfunction

   // sine of a first-quadrant remainder, taylor series in unsigned q2.30
   function automatic longint quarter_sine(input longint unsigned g);
      longint unsigned one, x, x2, h, s, d;
      one = longint'(1) << etm_pkg::WORK_BITS;
      x = (g * longint'(etm_pkg::HALF_PI_WORK)) >> (ABITS - 2);
      x2 = (x * x) >> etm_pkg::WORK_BITS;
      h = one;
      for (int k = etm_pkg::SERIES_TERMS; k >= 1; k--) begin
         d = longint'(2 * k) * longint'(2 * k + 1);
         h = one - ((x2 * h) >> etm_pkg::WORK_BITS) / d;
      end
      s = (x * h) >> etm_pkg::WORK_BITS;
      if (s > one) s = one;
      return longint'((s + (longint'(1) << (etm_pkg::WORK_BITS - FRAC - 1)))
                      >> (etm_pkg::WORK_BITS - FRAC));
   endfunction

   function automatic void angle_trig(input logic [etm_pkg::ANGLE_W-1:0] a,
                                      output longint sn, output longint cs);
      longint unsigned quarter, f;
      longint s, c;
      etm_pkg::quad_type q;
      quarter = longint'(1) << (ABITS - 2);
      q = etm_pkg::quad_type'(a[ABITS-1 -: 2]);
      f = a & (quarter - 1);
      s = quarter_sine(f);
      c = quarter_sine(quarter - f);
      case (q)
         etm_pkg::QUAD_0: begin sn = s;  cs = c;  end
         etm_pkg::QUAD_1: begin sn = c;  cs = -s; end
         etm_pkg::QUAD_2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   function automatic logic signed [etm_pkg::ENTRY_W-1:0] scaled_entry(input longint k,
                                                                       input longint r);
      longint v;
      v = fx_mul(k, r);
      if (v > etm_pkg::ENTRY_MAX) v = etm_pkg::ENTRY_MAX;
      if (v < etm_pkg::ENTRY_MIN) v = etm_pkg::ENTRY_MIN;
      return v[etm_pkg::ENTRY_W-1:0];
   endfunction

   function automatic matrix_type model_matrix(input transform_type t);
      longint sx, cx, sy, cy, sz, cz, kx, ky, kz;
      matrix_type m;
      angle_trig(t.ax, sx, cx);
      angle_trig(t.ay, sy, cy);
      angle_trig(t.az, sz, cz);
      kx = t.kx; ky = t.ky; kz = t.kz;
      m.m00 = scaled_entry(kx, fx_mul(cy, cz) + fx_mul(fx_mul(sy, sx), sz));
      m.m01 = scaled_entry(kx, fx_mul(cx, sz));
      m.m02 = scaled_entry(kx, fx_mul(fx_mul(cy, sx), sz) - fx_mul(cz, sy));
      m.m10 = scaled_entry(ky, fx_mul(fx_mul(cz, sy), sx) - fx_mul(cy, sz));
      m.m11 = scaled_entry(ky, fx_mul(cx, cz));
      m.m12 = scaled_entry(ky, fx_mul(fx_mul(cy, cz), sx) + fx_mul(sy, sz));
      m.m20 = scaled_entry(kz, fx_mul(cx, sy));
      m.m21 = scaled_entry(kz, -sx);
      m.m22 = scaled_entry(kz, fx_mul(cy, cx));
      m.tx = t.tx; m.ty = t.ty; m.tz = t.tz;
      return m;
   endfunction

   // ---------------- directed table ----------------

   typedef struct {
      transform_type stim;
      bit known;
      matrix_type result;
   } table_row_type;

   localparam logic signed [etm_pkg::SCALE_W-1:0] ONE = 24'sh010000;
   localparam logic signed [etm_pkg::SCALE_W-1:0] SMAX = 24'sh7FFFFF;
   localparam logic signed [etm_pkg::SCALE_W-1:0] SMIN = 24'sh800000;

   table_row_type directed_rows[$];

   function automatic transform_type make_tf(input logic [15:0] ax, ay, az,
                                             input logic signed [23:0] kx, ky, kz,
                                             input logic signed [31:0] tx, ty, tz);
      transform_type t;
      t.ax = ax; t.ay = ay; t.az = az;
      t.kx = kx; t.ky = ky; t.kz = kz;
      t.tx = tx; t.ty = ty; t.tz = tz;
      return t;
   endfunction

   task automatic add_row(input transform_type t, input bit known, input matrix_type m);
      table_row_type r;
      r.stim = t; r.known = known; r.result = m;
      directed_rows.push_back(r);
   endtask

   task automatic build_table();
      matrix_type m;
      // zero angles, unit scale: identity
      m = '{24'sh010000, 0, 0, 0, 24'sh010000, 0, 0, 0, 24'sh010000, 32'sd5, -32'sd7, 32'sd0};
      add_row(make_tf(0, 0, 0, ONE, ONE, ONE, 5, -7, 0), 1'b1, m);
      // zero scale gives a zero matrix, translation extremes pass through
      m = '0;
      m.tx = 32'h7FFFFFFF; m.ty = 32'h80000000; m.tz = 32'hFFFFFFFF;
      add_row(make_tf(16'h1234, 16'hFFFF, 16'h8000, 0, 0, 0,
                      32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF), 1'b1, m);
      // quarter turns, quadrant edges and the last angle code
      add_row(make_tf(16'h4000, 0, 0, ONE, ONE, ONE, 0, 0, 0), 1'b0, m);
      add_row(make_tf(0, 16'h4000, 0, ONE, ONE, ONE, 0, 0, 0), 1'b0, m);
      add_row(make_tf(0, 0, 16'h4000, ONE, ONE, ONE, 0, 0, 0), 1'b0, m);
      add_row(make_tf(16'h8000, 16'h8000, 16'h8000, ONE, ONE, ONE, 1, 2, 3), 1'b0, m);
      add_row(make_tf(16'hC000, 16'hC000, 16'hC000, ONE, ONE, ONE, 1, 2, 3), 1'b0, m);
      add_row(make_tf(16'h3FFF, 16'h7FFF, 16'hBFFF, ONE, ONE, ONE, 0, 0, 0), 1'b0, m);
      add_row(make_tf(16'hFFFF, 16'hFFFF, 16'hFFFF, ONE, ONE, ONE, 0, 0, 0), 1'b0, m);
      add_row(make_tf(16'h0001, 16'h4001, 16'h8001, ONE, ONE, ONE, 0, 0, 0), 1'b0, m);
      add_row(make_tf(16'h2000, 16'h6000, 16'hE000, ONE, ONE, ONE, 0, 0, 0), 1'b0, m);
      // scale extremes, saturation on both sides
      add_row(make_tf(0, 0, 0, SMAX, SMAX, SMAX, 0, 0, 0), 1'b0, m);
      add_row(make_tf(0, 0, 0, SMIN, SMIN, SMIN, 0, 0, 0), 1'b0, m);
      add_row(make_tf(16'h8000, 16'h8000, 16'h8000, SMIN, SMIN, SMIN, 0, 0, 0), 1'b0, m);
      add_row(make_tf(16'h2000, 16'h2000, 16'h2000, SMAX, SMIN, SMAX, 0, 0, 0), 1'b0, m);
      add_row(make_tf(16'h5555, 16'hAAAA, 16'h1357, 24'sh000001, 24'shFFFFFF, ONE,
                      32'h55555555, 32'hAAAAAAAA, 0), 1'b0, m);
      add_row(make_tf(16'h0100, 16'hF000, 16'h7123, -ONE, 24'sh018000, 24'shFE8000,
                      -1, 1, 32'h00010000), 1'b0, m);
   endtask

   // ---------------- sender ----------------

   // valid drops only for an idle burst, so back-to-back items keep it high
   task automatic send_transform(input transform_type t);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_item <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   function automatic logic signed [etm_pkg::SCALE_W-1:0] random_scale();
      case ($urandom_range(0, 5))
         0: return SMAX;
         1: return SMIN;
         2: return $signed(24'($urandom_range(0, 32'h3FFFF))) - 24'sh20000;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic transform_type random_transform();
      transform_type t;
      t.ax = 16'($urandom); t.ay = 16'($urandom); t.az = 16'($urandom);
      t.kx = random_scale(); t.ky = random_scale(); t.kz = random_scale();
      t.tx = $urandom; t.ty = $urandom; t.tz = $urandom;
      return t;
   endfunction

   // known rows get their typed result queued, the rest are predicted
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_matrices.push_back(row_known ? row_result : model_matrix(req_item));
   end

   // ---------------- receiver ----------------

   always @(negedge clock) begin
      if (reset || rx_hold)
         rsp_ready <= 1'b0;
      else if (quiet_phase)
         rsp_ready <= 1'b1;
      else if (!rsp_ready)
         rsp_ready <= 1'b1;
      else if ($urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 19) - 1) @(negedge clock);
      end
   end

   // compare each result with the oldest expected matrix
   always @(posedge clock) begin
      matrix_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_matrices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_item);
         end else begin
            want = expected_matrices.pop_front();
            if (want !== rsp_item) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch on result %0d", results_seen);
                  $display("  exp %h %h %h | %h %h %h | %h %h %h | %h %h %h",
                           want.m00, want.m01, want.m02, want.m10, want.m11, want.m12,
                           want.m20, want.m21, want.m22, want.tx, want.ty, want.tz);
                  $display("  got %h %h %h | %h %h %h | %h %h %h | %h %h %h",
                           rsp_item.m00, rsp_item.m01, rsp_item.m02, rsp_item.m10,
                           rsp_item.m11, rsp_item.m12, rsp_item.m20, rsp_item.m21,
                           rsp_item.m22, rsp_item.tx, rsp_item.ty, rsp_item.tz);
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired with %0d items pending", expected_matrices.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      int wait_cycles;
      build_table();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows, typed results checked against the predictor first
      foreach (directed_rows[i]) begin
         if (directed_rows[i].known &&
             model_matrix(directed_rows[i].stim) !== directed_rows[i].result) begin
            mismatches++;
            $display("typed result differs from prediction on row %0d", i);
         end
         row_known = directed_rows[i].known;
         row_result = directed_rows[i].result;
         send_transform(directed_rows[i].stim);
      end
      row_known = 1'b0;

      // long receiver hold-off while the sender keeps offering items
      fork
         begin
            rx_hold = 1'b1;
            repeat (120) @(negedge clock);
            rx_hold = 1'b0;
         end
         begin
            repeat (60) send_transform(random_transform());
            req_valid <= 1'b0;
         end
      join

      // sender pause until every pending result has arrived
      do @(negedge clock); while (expected_matrices.size() != 0);

      for (int n = 0; n < N_RANDOM - 60; n++) begin
         if (n == N_RANDOM - 160) quiet_phase = 1'b1;
         send_transform(random_transform());
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (expected_matrices.size() != 0);
      wait_cycles = 0;
      while (wait_cycles < DRAIN_CYCLES) begin
         @(negedge clock);
         wait_cycles++;
      end

      $display("sent %0d transforms (%0d directed), checked %0d result matrices",
               items_sent, directed_rows.size(), results_seen);
      $display("covered quadrant edges, scale saturation, stalls and back-pressure");
      if (mismatches == 0 && expected_matrices.size() == 0)
         $display("*** PASSED ***");
      else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_matrices.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
